// ===== src/s3i_pkg.sv =====
package s3i_pkg;

	localparam int EW = 32;
	localparam int PW = 2 * EW;
	localparam int CW = PW + 1;
	localparam int MW = PW;
	localparam int DW = 97;
	localparam int OW = 48;
	localparam int NUM_SHIFT = 40;
	localparam int LOW_W = OW - NUM_SHIFT;
	localparam int TOP_W = MW - LOW_W;
	localparam int LANES = 9;
	localparam int NPROD = 2 * LANES;
	localparam int IDX_W = 4;
	localparam int HALF_W = EW;
	localparam int HI_W = CW - HALF_W;
	localparam int PP_W = EW + HI_W;
	localparam int SUM_W = PP_W + 2;

	localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] OUT_MIN_MAG = {1'b1, {(OW-1){1'b0}}};

	// operand indices (a, b, c, d) of the minor a*b - c*d at each output position
	localparam logic [IDX_W-1:0] MINOR_IDX [LANES][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd3, 4'd8, 4'd5, 4'd6}, '{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd8, 4'd2, 4'd7}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd0, 4'd7, 4'd1, 4'd6},
		'{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd0, 4'd5, 4'd2, 4'd3}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic ovf;
		logic qneg;
	} s3i_tag_t;

endpackage

// ===== src/s3i_div.sv =====
module s3i_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_sing,
	input  logic [s3i_pkg::DW-1:0]       in_dmag,
	input  logic [s3i_pkg::DW-1:0]       in_rem   [s3i_pkg::LANES],
	input  logic [s3i_pkg::LOW_W-1:0]    in_low   [s3i_pkg::LANES],
	input  s3i_pkg::s3i_tag_t            in_tag   [s3i_pkg::LANES],
	output logic                         out_valid,
	output logic                         out_sing,
	output logic [s3i_pkg::OW-1:0]       out_q    [s3i_pkg::LANES],
	output s3i_pkg::s3i_tag_t            out_tag  [s3i_pkg::LANES]
);

	localparam int STEPS = s3i_pkg::OW;
	localparam int DW = s3i_pkg::DW;
	localparam int LANES = s3i_pkg::LANES;

	logic                          v_s    [1:STEPS];
	logic                          sing_s [1:STEPS];
	logic [DW-1:0]                 dm_s   [1:STEPS];
	logic [DW-1:0]                 rem_s  [1:STEPS][LANES];
	logic [STEPS-1:0]              q_s    [1:STEPS][LANES];
	logic [s3i_pkg::LOW_W-1:0]     low_s  [1:STEPS][LANES];
	s3i_pkg::s3i_tag_t             tag_s  [1:STEPS][LANES];

	// one quotient bit per stage, most significant first
	for (genvar t = 0; t < STEPS; t++) begin : g_step
		localparam int BI = STEPS - 1 - t;
		logic                      cur_v;
		logic                      cur_sing;
		logic [DW-1:0]             cur_dm;
		logic [DW-1:0]             cur_rem [LANES];
		logic [STEPS-1:0]          cur_q   [LANES];
		logic [s3i_pkg::LOW_W-1:0] cur_low [LANES];
		s3i_pkg::s3i_tag_t         cur_tag [LANES];

		if (t == 0) begin : g_first
			assign cur_v = in_valid;
			assign cur_sing = in_sing;
			assign cur_dm = in_dmag;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign cur_rem[l] = in_rem[l];
				assign cur_q[l] = '0;
				assign cur_low[l] = in_low[l];
				assign cur_tag[l] = in_tag[l];
			end
		end else begin : g_mid
			assign cur_v = v_s[t];
			assign cur_sing = sing_s[t];
			assign cur_dm = dm_s[t];
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign cur_rem[l] = rem_s[t][l];
				assign cur_q[l] = q_s[t][l];
				assign cur_low[l] = low_s[t][l];
				assign cur_tag[l] = tag_s[t][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[t+1] <= 1'b0;
			end else begin
				v_s[t+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			sing_s[t+1] <= cur_sing;
			dm_s[t+1] <= cur_dm;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic          nb;
			logic [DW:0]   shifted;
			logic [DW:0]   diff;
			logic          ge;

			if (BI >= s3i_pkg::NUM_SHIFT) begin : g_nb
				assign nb = cur_low[l][BI - s3i_pkg::NUM_SHIFT];
			end else begin : g_zero
				assign nb = 1'b0;
			end

			assign shifted = {cur_rem[l], nb};
			assign diff = shifted - {1'b0, cur_dm};
			assign ge = shifted >= {1'b0, cur_dm};

			always_ff @(posedge clk) begin
				rem_s[t+1][l] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				q_s[t+1][l] <= {cur_q[l][STEPS-2:0], ge};
				low_s[t+1][l] <= cur_low[l];
				tag_s[t+1][l] <= cur_tag[l];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_sing = sing_s[STEPS];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_q[l] = q_s[STEPS][l];
		assign out_tag[l] = tag_s[STEPS][l];
	end

endmodule

// ===== src/symmetric_3x3_inverse.sv =====
// Inverse of a symmetric 3x3 matrix by cofactors over the determinant. Raise
// start with nine signed Q16.16 entries; busy stays low, so a new matrix may be
// transferred in every clock cycle. Each result appears on the inv ports and
// singular for exactly one cycle, marked by done, after passing 56 register
// stages: 7 arithmetic stages, 48 quotient-bit stages of the nine-lane long
// divider and one output stage; the edge that takes the matrix loads the first.
// The receiver cannot stall: capture results
// when done is high. Outputs are signed Q24.24 truncated toward zero and
// saturated; a zero determinant gives singular high and all-zero outputs.
// Cofactors are not transposed, so non-symmetric input yields the transpose.
module symmetric_3x3_inverse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [s3i_pkg::EW-1:0] m00,
	input  logic signed [s3i_pkg::EW-1:0] m01,
	input  logic signed [s3i_pkg::EW-1:0] m02,
	input  logic signed [s3i_pkg::EW-1:0] m10,
	input  logic signed [s3i_pkg::EW-1:0] m11,
	input  logic signed [s3i_pkg::EW-1:0] m12,
	input  logic signed [s3i_pkg::EW-1:0] m20,
	input  logic signed [s3i_pkg::EW-1:0] m21,
	input  logic signed [s3i_pkg::EW-1:0] m22,
	output logic                          done,
	output logic signed [s3i_pkg::OW-1:0] inv00,
	output logic signed [s3i_pkg::OW-1:0] inv01,
	output logic signed [s3i_pkg::OW-1:0] inv02,
	output logic signed [s3i_pkg::OW-1:0] inv10,
	output logic signed [s3i_pkg::OW-1:0] inv11,
	output logic signed [s3i_pkg::OW-1:0] inv12,
	output logic signed [s3i_pkg::OW-1:0] inv20,
	output logic signed [s3i_pkg::OW-1:0] inv21,
	output logic signed [s3i_pkg::OW-1:0] inv22,
	output logic                          singular
);

	localparam int EW = s3i_pkg::EW;
	localparam int PW = s3i_pkg::PW;
	localparam int CW = s3i_pkg::CW;
	localparam int MW = s3i_pkg::MW;
	localparam int DW = s3i_pkg::DW;
	localparam int OW = s3i_pkg::OW;
	localparam int LANES = s3i_pkg::LANES;
	localparam int PP_W = s3i_pkg::PP_W;
	localparam int SUM_W = s3i_pkg::SUM_W;
	localparam int HALF_W = s3i_pkg::HALF_W;

	// the pipeline never stalls, so a transfer happens whenever start is high
	assign busy = 1'b0;

	logic signed [EW-1:0] e_in [LANES];
	assign e_in = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

	// Stage 1: every two-entry product that any minor needs, exact Q32.32
	logic                 v_s1;
	logic signed [PW-1:0] p_s1 [s3i_pkg::NPROD];
	logic signed [EW-1:0] e_s1 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			p_s1[2*k] <= PW'(e_in[s3i_pkg::MINOR_IDX[k][0]])
				* PW'(e_in[s3i_pkg::MINOR_IDX[k][1]]);
			p_s1[2*k+1] <= PW'(e_in[s3i_pkg::MINOR_IDX[k][2]])
				* PW'(e_in[s3i_pkg::MINOR_IDX[k][3]]);
		end
		for (int j = 0; j < 3; j++) begin
			e_s1[j] <= e_in[j];
		end
	end

	// Stage 2: signed cofactors; odd positions take the minor negated
	logic                 v_s2;
	logic signed [CW-1:0] cof_s2 [LANES];
	logic signed [EW-1:0] e_s2 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			if (k % 2 == 1) begin
				cof_s2[k] <= CW'(p_s1[2*k+1]) - CW'(p_s1[2*k]);
			end else begin
				cof_s2[k] <= CW'(p_s1[2*k]) - CW'(p_s1[2*k+1]);
			end
		end
		e_s2 <= e_s1;
	end

	// Stage 3: det = sum of row-0 entries times their cofactors, each product
	// split into low and high halves of the cofactor; cofactor sign and size
	logic                   v_s3;
	logic signed [PP_W-1:0] lo_s3 [3];
	logic signed [PP_W-1:0] hi_s3 [3];
	logic                   cneg_s3 [LANES];
	logic [MW-1:0]          cmag_s3 [LANES];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			lo_s3[j] <= PP_W'(e_s2[j]) * PP_W'($signed({1'b0, cof_s2[j][HALF_W-1:0]}));
			hi_s3[j] <= PP_W'(e_s2[j]) * PP_W'($signed(cof_s2[j][CW-1:HALF_W]));
		end
		for (int k = 0; k < LANES; k++) begin
			cneg_s3[k] <= cof_s2[k][CW-1];
			cmag_s3[k] <= cof_s2[k][CW-1] ? MW'(-cof_s2[k]) : MW'(cof_s2[k]);
		end
	end

	// Stage 4: sum the low and high partial products apart
	logic                    v_s4;
	logic signed [SUM_W-1:0] slo_s4;
	logic signed [SUM_W-1:0] shi_s4;
	logic                    cneg_s4 [LANES];
	logic [MW-1:0]           cmag_s4 [LANES];

	always_ff @(posedge clk) begin
		slo_s4 <= SUM_W'(lo_s3[0]) + SUM_W'(lo_s3[1]) + SUM_W'(lo_s3[2]);
		shi_s4 <= SUM_W'(hi_s3[0]) + SUM_W'(hi_s3[1]) + SUM_W'(hi_s3[2]);
		cneg_s4 <= cneg_s3;
		cmag_s4 <= cmag_s3;
	end

	// Stage 5: join the halves into the exact determinant at scale 2^48
	logic                 v_s5;
	logic signed [DW-1:0] det_s5;
	logic                 cneg_s5 [LANES];
	logic [MW-1:0]        cmag_s5 [LANES];

	always_ff @(posedge clk) begin
		det_s5 <= (DW'(shi_s4) <<< HALF_W) + DW'(slo_s4);
		cneg_s5 <= cneg_s4;
		cmag_s5 <= cmag_s4;
	end

	// Stage 6: determinant sign, magnitude and zero test
	logic          v_s6;
	logic          sing_s6;
	logic          dneg_s6;
	logic [DW-1:0] dmag_s6;
	logic          cneg_s6 [LANES];
	logic [MW-1:0] cmag_s6 [LANES];

	always_ff @(posedge clk) begin
		sing_s6 <= (det_s5 == '0);
		dneg_s6 <= det_s5[DW-1];
		dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
		cneg_s6 <= cneg_s5;
		cmag_s6 <= cmag_s5;
	end

	// Stage 7: the numerator is |cof| * 2^40; a quotient of 2^48 or more is
	// flagged up front, so the divider only needs the lower 48 quotient bits
	logic                      v_s7;
	logic                      sing_s7;
	logic [DW-1:0]             dmag_s7;
	logic [DW-1:0]             rem_s7 [LANES];
	logic [s3i_pkg::LOW_W-1:0] low_s7 [LANES];
	s3i_pkg::s3i_tag_t         tag_s7 [LANES];

	always_ff @(posedge clk) begin
		sing_s7 <= sing_s6;
		dmag_s7 <= dmag_s6;
		for (int k = 0; k < LANES; k++) begin
			rem_s7[k] <= DW'(cmag_s6[k][MW-1:s3i_pkg::LOW_W]);
			low_s7[k] <= cmag_s6[k][s3i_pkg::LOW_W-1:0];
			tag_s7[k].ovf <= DW'(cmag_s6[k][MW-1:s3i_pkg::LOW_W]) >= dmag_s6;
			tag_s7[k].qneg <= cneg_s6[k] != dneg_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	logic              dv_valid;
	logic              dv_sing;
	logic [OW-1:0]     dv_q   [LANES];
	s3i_pkg::s3i_tag_t dv_tag [LANES];

	s3i_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.in_sing  (sing_s7),
		.in_dmag  (dmag_s7),
		.in_rem   (rem_s7),
		.in_low   (low_s7),
		.in_tag   (tag_s7),
		.out_valid(dv_valid),
		.out_sing (dv_sing),
		.out_q    (dv_q),
		.out_tag  (dv_tag)
	);

	// Output stage: apply sign, saturate, and zero everything when singular
	logic [OW-1:0] res [LANES];

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (dv_sing) begin
				res[k] = '0;
			end else if (dv_tag[k].qneg && (dv_tag[k].ovf || dv_q[k] != '0)) begin
				if (dv_tag[k].ovf || (dv_q[k][OW-1] && dv_q[k][OW-2:0] != '0)) begin
					res[k] = -s3i_pkg::OUT_MIN_MAG;
				end else begin
					res[k] = -dv_q[k];
				end
			end else begin
				if (dv_tag[k].ovf || dv_q[k][OW-1]) begin
					res[k] = s3i_pkg::OUT_MAX;
				end else begin
					res[k] = dv_q[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		inv00 <= res[0];
		inv01 <= res[1];
		inv02 <= res[2];
		inv10 <= res[3];
		inv11 <= res[4];
		inv12 <= res[5];
		inv20 <= res[6];
		inv21 <= res[7];
		inv22 <= res[8];
		singular <= dv_sing;
	end

endmodule

// ===== tb/symmetric_3x3_inverse_tb.sv =====
module symmetric_3x3_inverse_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EW = s3i_pkg::EW;
	localparam int OW = s3i_pkg::OW;
	localparam int LANES = s3i_pkg::LANES;
	localparam int NUM_SHIFT = s3i_pkg::NUM_SHIFT;

	localparam int NUM_RANDOM = 480;
	localparam int DRAIN_CYCLES = 80;
	localparam logic signed [127:0] QUOT_MAX = 128'sh7FFF_FFFF_FFFF;
	localparam logic signed [127:0] QUOT_MIN = -QUOT_MAX - 1;
	localparam logic [OW-1:0] ONE_Q24 = 48'h0000_0100_0000;
	localparam logic [OW-1:0] NEG_ONE_Q24 = -ONE_Q24;
	localparam logic [OW-1:0] RAW1_INV = 48'h0100_0000_0000;
	localparam logic [EW-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [EW-1:0] NEG_ONE_Q16 = -ONE_Q16;
	localparam logic [EW-1:0] EMAX = 32'h7FFF_FFFF;
	localparam logic [EW-1:0] EMIN = 32'h8000_0000;
	localparam logic [EW-1:0] BIG = 32'h4000_0000;

	typedef logic [LANES-1:0][EW-1:0] matrix_t;

	typedef struct packed {
		logic [LANES-1:0][OW-1:0] inv;
		logic                     singular;
	} inverse_t;

	typedef struct packed {
		matrix_t  m;
		logic     typed;
		inverse_t want;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	matrix_t mat = '0;
	logic [LANES-1:0][OW-1:0] inv_out;
	logic singular;

	inverse_t pending_inverse = '0;
	inverse_t inverse_q[$];
	int mismatches = 0;
	int transfers = 0;
	int results_seen = 0;
	int singular_seen = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	symmetric_3x3_inverse i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m00(mat[0]), .m01(mat[1]), .m02(mat[2]),
		.m10(mat[3]), .m11(mat[4]), .m12(mat[5]),
		.m20(mat[6]), .m21(mat[7]), .m22(mat[8]),
		.done(done),
		.inv00(inv_out[0]), .inv01(inv_out[1]), .inv02(inv_out[2]),
		.inv10(inv_out[3]), .inv11(inv_out[4]), .inv12(inv_out[5]),
		.inv20(inv_out[6]), .inv21(inv_out[7]), .inv22(inv_out[8]),
		.singular(singular)
	);

	// Exact cofactor-over-determinant: wide signed math, truncating divide, saturate.
	function automatic inverse_t cofactor_inverse(matrix_t m);
		logic signed [127:0] e [LANES];
		logic signed [127:0] det, p1, p2, cof, num, q;
		inverse_t r;
		r = '0;
		for (int k = 0; k < LANES; k++) begin
			e[k] = $signed(m[k]);
		end
		det = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[3] * e[7] * e[2]
			- e[2] * e[4] * e[6] - e[1] * e[3] * e[8] - e[0] * e[5] * e[7];
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int k = 0; k < LANES; k++) begin
			p1 = e[s3i_pkg::MINOR_IDX[k][0]] * e[s3i_pkg::MINOR_IDX[k][1]];
			p2 = e[s3i_pkg::MINOR_IDX[k][2]] * e[s3i_pkg::MINOR_IDX[k][3]];
			// odd positions carry the negative cofactor sign
			cof = (k % 2) ? p2 - p1 : p1 - p2;
			num = cof <<< NUM_SHIFT;
			q = num / det;
			if (q > QUOT_MAX)
				q = QUOT_MAX;
			else if (q < QUOT_MIN)
				q = QUOT_MIN;
			r.inv[k] = q[OW-1:0];
		end
		return r;
	endfunction

	function automatic logic [EW-1:0] random_entry(int kind);
		case (kind)
			0: return $urandom();
			1: return EW'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
			2: return ($urandom_range(0, 1)) ? EMAX - $urandom_range(0, 3)
				: EMIN + $urandom_range(0, 3);
			default: return EW'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	// Draw a matrix: symmetric ones, raw noise, singular (repeated row) and
	// near-singular shapes, with entries drawn full-range, small, extreme or tiny.
	function automatic matrix_t random_matrix();
		matrix_t m;
		int shape, kind;
		shape = $urandom_range(0, 9);
		kind = $urandom_range(0, 3);
		for (int k = 0; k < LANES; k++) begin
			m[k] = random_entry(kind);
		end
		case (shape)
			0, 1, 2, 3: begin
				m[3] = m[1];
				m[6] = m[2];
				m[7] = m[5];
			end
			4: begin
				m[6] = m[0];
				m[7] = m[1];
				m[8] = m[2];
			end
			5: begin
				m[0] = BIG;
				m[1] = BIG - 1;
				m[3] = BIG + 1;
				m[4] = BIG;
				m[2] = 0;
				m[5] = 0;
				m[6] = 0;
				m[7] = 0;
				m[8] = $urandom_range(1, 4);
			end
			default: ;
		endcase
		return m;
	endfunction

	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 90);
	endfunction

	// Sample at the rising edge: record transfers, compare strobed results.
	always @(posedge clk) begin
		inverse_t want;
		if (start && !busy) begin
			inverse_q.push_back(pending_inverse);
			transfers++;
		end
		if (done) begin
			results_seen++;
			if (singular)
				singular_seen++;
			if (inverse_q.size() == 0) begin
				$display("%0t: result with none expected: singular %0b inv %h",
					$time, singular, inv_out);
				mismatches++;
			end else begin
				want = inverse_q.pop_front();
				if (singular !== want.singular) begin
					$display("%0t: singular expected %0b actual %0b",
						$time, want.singular, singular);
					mismatches++;
				end
				for (int k = 0; k < LANES; k++) begin
					if (inv_out[k] !== want.inv[k]) begin
						$display("%0t: inv%0d%0d expected %h actual %h",
							$time, k / 3, k % 3, want.inv[k], inv_out[k]);
						mismatches++;
					end
				end
			end
		end
	end

	// Hold the matrix with start high until it transfers, then advance.
	task automatic send_matrix(matrix_t m, inverse_t want);
		mat <= m;
		pending_inverse <= want;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	vector_t vectors [$];

	task automatic add_vector(matrix_t m, logic typed, inverse_t want);
		vector_t v;
		v.m = m;
		v.typed = typed;
		v.want = typed ? want : '0;
		vectors.push_back(v);
	endtask

	initial begin
		inverse_t w;
		matrix_t m;
		int gap;

		// Zero matrix: singular, all outputs zero.
		w = '0;
		w.singular = 1'b1;
		add_vector('0, 1'b1, w);
		// Identity and its negation.
		m = '0;
		m[0] = ONE_Q16;
		m[4] = ONE_Q16;
		m[8] = ONE_Q16;
		w = '0;
		w.inv[0] = ONE_Q24;
		w.inv[4] = ONE_Q24;
		w.inv[8] = ONE_Q24;
		add_vector(m, 1'b1, w);
		m[0] = NEG_ONE_Q16;
		m[4] = NEG_ONE_Q16;
		m[8] = NEG_ONE_Q16;
		w.inv[0] = NEG_ONE_Q24;
		w.inv[4] = NEG_ONE_Q24;
		w.inv[8] = NEG_ONE_Q24;
		add_vector(m, 1'b1, w);
		// Smallest nonzero diagonal.
		m = '0;
		m[0] = 1;
		m[4] = 1;
		m[8] = 1;
		w = '0;
		w.inv[0] = RAW1_INV;
		w.inv[4] = RAW1_INV;
		w.inv[8] = RAW1_INV;
		add_vector(m, 1'b1, w);
		// Rank-one matrices are singular.
		w = '0;
		w.singular = 1'b1;
		add_vector({LANES{EMAX}}, 1'b1, w);
		add_vector({LANES{EMIN}}, 1'b1, w);
		add_vector({LANES{32'hFFFF_FFFF}}, 1'b1, w);
		// Extreme diagonals and mixed extremes.
		m = '0;
		m[0] = EMAX;
		m[4] = EMAX;
		m[8] = EMAX;
		add_vector(m, 1'b0, w);
		m[0] = EMIN;
		m[4] = EMIN;
		m[8] = EMIN;
		add_vector(m, 1'b0, w);
		add_vector({EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX}, 1'b0, w);
		add_vector({EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMAX}, 1'b0, w);
		add_vector({EMIN, EMIN, EMAX, EMIN, EMAX, EMAX, EMAX, EMAX, EMIN}, 1'b0, w);
		// Near-singular shape with a tiny determinant: drives both saturations.
		m = '0;
		m[0] = BIG;
		m[1] = BIG - 1;
		m[3] = BIG + 1;
		m[4] = BIG;
		m[8] = 1;
		add_vector(m, 1'b0, w);
		m[8] = NEG_ONE_Q16 >>> 16;
		add_vector(m, 1'b0, w);
		// Symmetric covariance-like and non-symmetric inputs.
		add_vector({32'h0003_0000, 32'h0000_8000, 32'hFFFF_4000,
			32'h0000_8000, 32'h0002_0000, 32'h0000_2000,
			32'hFFFF_4000, 32'h0000_2000, 32'h0001_8000}, 1'b0, w);
		add_vector({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0000_0000, 32'h0001_0000, 32'h0004_0000,
			32'h0005_0000, 32'h0006_0000, 32'h0000_0000}, 1'b0, w);
		add_vector({32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
			32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0007,
			32'h0000_0004, 32'hFFFF_FFFE, 32'h0000_0009}, 1'b0, w);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (vectors[i]) begin
			send_matrix(vectors[i].m,
				vectors[i].typed ? vectors[i].want : cofactor_inverse(vectors[i].m));
			hold_off(idle_gap());
		end

		for (int n = 0; n < NUM_RANDOM; n++) begin
			m = random_matrix();
			send_matrix(m, cofactor_inverse(m));
			// back-to-back stretch, and one full drain of the pipeline midway
			gap = (n >= 150 && n < 220) ? 0 : idle_gap();
			if (n == 300) begin
				start <= 1'b0;
				while (inverse_q.size() != 0)
					@(negedge clk);
				gap = $urandom_range(1, 5);
				repeat (gap) @(negedge clk);
			end else begin
				hold_off(gap);
			end
		end
		start <= 1'b0;

		while (inverse_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d matrix transfers, %0d results, %0d singular",
			transfers, results_seen, singular_seen);
		$display("directed extremes, saturation and singular cases plus random symmetric mixes");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", inverse_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
